// ===== design/qrs_pkg.sv =====
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared widths, types and helpers for the quadratic root solver pipeline.
// ----------------------------------------------------------------------------
package qrs_pkg;

	localparam int WORD_BITS  = 32;
	localparam int FRAC_BITS  = 16;
	localparam int TOL_W      = 16;

	localparam int PROD_W     = 2 * WORD_BITS;
	localparam int D_W        = 2 * WORD_BITS + 3;
	localparam int RAD_W      = 2 * WORD_BITS + 2;
	localparam int ROOT_W     = WORD_BITS + 1;
	localparam int SQ_STEPS   = ROOT_W;
	localparam int SQ_REM_W   = ROOT_W + 2;
	localparam int NUM_W      = WORD_BITS + 3;
	localparam int DEN_W      = WORD_BITS + 2;
	localparam int DIVIDEND_W = NUM_W + FRAC_BITS;
	localparam int DIV_STEPS  = DIVIDEND_W;

	localparam logic [DIVIDEND_W-1:0] Q_MAX_POS = DIVIDEND_W'((64'd1 << (WORD_BITS - 1)) - 64'd1);
	localparam logic [DIVIDEND_W-1:0] Q_MAX_NEG = DIVIDEND_W'(64'd1 << (WORD_BITS - 1));

	typedef enum logic [1:0] {
		CNT_NONE = 2'd0,
		CNT_ONE  = 2'd1,
		CNT_TWO  = 2'd2,
		CNT_INF  = 2'd3
	} count_t;

	typedef struct packed {
		count_t                   count;
		logic                     use1;
		logic                     use2;
		logic                     use_sqrt;
		logic signed [NUM_W-1:0]  base;
		logic signed [DEN_W:0]    den;
	} ctx_pre_t;

	typedef struct packed {
		count_t count;
		logic   use1;
		logic   use2;
		logic   neg1;
		logic   neg2;
	} ctx_div_t;

	function automatic logic [WORD_BITS-1:0] mag_word(input logic signed [WORD_BITS-1:0] v);
		mag_word = v[WORD_BITS-1] ? WORD_BITS'(-v) : WORD_BITS'(v);
	endfunction

endpackage

// ===== design/qrs_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// qrs_sqrt_cell
// One registered step of the digit-by-digit integer square root.
// ----------------------------------------------------------------------------
module qrs_sqrt_cell (
	input  logic                              clk,
	input  logic                              en,
	input  logic [qrs_pkg::RAD_W-1:0]         rad_in,
	input  logic [qrs_pkg::SQ_REM_W-1:0]      rem_in,
	input  logic [qrs_pkg::ROOT_W-1:0]        root_in,
	output logic [qrs_pkg::RAD_W-1:0]         rad_out,
	output logic [qrs_pkg::SQ_REM_W-1:0]      rem_out,
	output logic [qrs_pkg::ROOT_W-1:0]        root_out
);

	logic [qrs_pkg::SQ_REM_W+1:0] rem_sh;
	logic [qrs_pkg::SQ_REM_W+1:0] trial;
	logic [qrs_pkg::SQ_REM_W+1:0] rem_sub;
	logic                         ge;

	always_comb begin
		rem_sh  = {rem_in, rad_in[qrs_pkg::RAD_W-1 -: 2]};
		trial   = (qrs_pkg::SQ_REM_W+2)'({root_in, 2'b01});
		ge      = (rem_sh >= trial);
		rem_sub = rem_sh - trial;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_out  <= rad_in << 2;
			rem_out  <= ge ? rem_sub[qrs_pkg::SQ_REM_W-1:0] : rem_sh[qrs_pkg::SQ_REM_W-1:0];
			root_out <= {root_in[qrs_pkg::ROOT_W-2:0], ge};
		end
	end

endmodule

// ===== design/qrs_div_cell.sv =====
// ----------------------------------------------------------------------------
// qrs_div_cell
// One registered restoring-division step, one quotient bit per cell.
// ----------------------------------------------------------------------------
module qrs_div_cell (
	input  logic                              clk,
	input  logic                              en,
	input  logic [qrs_pkg::DEN_W-1:0]         den_in,
	input  logic [qrs_pkg::DIVIDEND_W-1:0]    dvd_in,
	input  logic [qrs_pkg::DEN_W-1:0]         rem_in,
	input  logic [qrs_pkg::DIVIDEND_W-1:0]    quo_in,
	output logic [qrs_pkg::DEN_W-1:0]         den_out,
	output logic [qrs_pkg::DIVIDEND_W-1:0]    dvd_out,
	output logic [qrs_pkg::DEN_W-1:0]         rem_out,
	output logic [qrs_pkg::DIVIDEND_W-1:0]    quo_out
);

	logic [qrs_pkg::DEN_W:0] rem_sh;
	logic [qrs_pkg::DEN_W:0] rem_sub;
	logic                    ge;

	always_comb begin
		rem_sh  = {rem_in, dvd_in[qrs_pkg::DIVIDEND_W-1]};
		ge      = (rem_sh >= {1'b0, den_in});
		rem_sub = rem_sh - {1'b0, den_in};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_out <= den_in;
			dvd_out <= dvd_in << 1;
			rem_out <= ge ? rem_sub[qrs_pkg::DEN_W-1:0] : rem_sh[qrs_pkg::DEN_W-1:0];
			quo_out <= {quo_in[qrs_pkg::DIVIDEND_W-2:0], ge};
		end
	end

endmodule

// ===== design/quadratic_root_solver.sv =====
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Real roots of a*x^2 + b*x + c = 0 in signed Q16.16, fully pipelined.
// ----------------------------------------------------------------------------
// pipeline: 3 setup stages, 33 square root cells, 1 numerator stage,
//   51 divider cells, 1 output stage
// throughput: one equation per cycle; the whole pipeline holds while a
//   finished result is stalled at the output register
// reset: clears all valid bits and sets zero_tolerance to 1
// ----------------------------------------------------------------------------
module quadratic_root_solver (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [qrs_pkg::TOL_W-1:0]             cfg_wr_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [qrs_pkg::WORD_BITS-1:0]  coef_a,
	input  logic signed [qrs_pkg::WORD_BITS-1:0]  coef_b,
	input  logic signed [qrs_pkg::WORD_BITS-1:0]  coef_c,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [qrs_pkg::WORD_BITS-1:0]  root_low,
	output logic signed [qrs_pkg::WORD_BITS-1:0]  root_high,
	output logic [1:0]                            root_count,
	output logic                                  status
);

	localparam int W  = qrs_pkg::WORD_BITS;
	localparam int SQ = qrs_pkg::SQ_STEPS;
	localparam int DV = qrs_pkg::DIV_STEPS;

	logic adv;
	logic [qrs_pkg::TOL_W-1:0] tol_q;

	// setup stages
	logic v_s1, v_s2, v_s3;
	logic signed [W-1:0] a_s1, b_s1, c_s1;
	logic signed [W-1:0] a_s2, b_s2, c_s2;
	logic [qrs_pkg::PROD_W-1:0] bb_s2, ac_s2;
	logic na_s2, nb_s2, nc_s2, ac_neg_s2;
	logic [qrs_pkg::RAD_W-1:0] rad_s3;
	qrs_pkg::ctx_pre_t ctx_s3;

	logic [W-1:0] ma, mb, mc, tol_w;
	logic [qrs_pkg::D_W-1:0] bb_x, ac4_x, d, d_mag, tol_d;
	logic d_neg, d_pos, d_near;
	qrs_pkg::ctx_pre_t ctx_nx;

	// square root chain
	logic [qrs_pkg::RAD_W-1:0]    sq_rad  [0:SQ];
	logic [qrs_pkg::SQ_REM_W-1:0] sq_rem  [0:SQ];
	logic [qrs_pkg::ROOT_W-1:0]   sq_root [0:SQ];
	logic                         vsq_q   [0:SQ-1];
	qrs_pkg::ctx_pre_t            ctxsq_q [0:SQ-1];

	// numerator stage
	logic v_n_q;
	qrs_pkg::ctx_div_t ctx_n_q;
	logic [qrs_pkg::DIVIDEND_W-1:0] dvd1_n_q, dvd2_n_q;
	logic [qrs_pkg::DEN_W-1:0] den_n_q;
	logic signed [qrs_pkg::NUM_W-1:0] s_ext, n1, n2;
	logic [qrs_pkg::NUM_W-1:0] n1_mag, n2_mag;
	logic signed [qrs_pkg::DEN_W:0] den_s, den_abs;
	qrs_pkg::ctx_pre_t ctx_last;

	// divider chains
	logic [qrs_pkg::DEN_W-1:0]      d1_den [0:DV], d2_den [0:DV];
	logic [qrs_pkg::DIVIDEND_W-1:0] d1_dvd [0:DV], d2_dvd [0:DV];
	logic [qrs_pkg::DEN_W-1:0]      d1_rem [0:DV], d2_rem [0:DV];
	logic [qrs_pkg::DIVIDEND_W-1:0] d1_quo [0:DV], d2_quo [0:DV];
	logic                           vdv_q   [0:DV-1];
	qrs_pkg::ctx_div_t              ctxdv_q [0:DV-1];

	// output stage
	logic out_valid_q;
	logic signed [W-1:0] root_low_q, root_high_q;
	qrs_pkg::count_t cnt_q;
	logic status_q;
	logic [W:0] fin1, fin2;
	qrs_pkg::ctx_div_t ctx_end;

	function automatic logic [W:0] finish_root(
		input logic [qrs_pkg::DIVIDEND_W-1:0] q,
		input logic                           neg,
		input logic [W-1:0]                   tol
	);
		logic         sat;
		logic [W-1:0] r;
		begin
			if (neg) begin
				sat = (q > qrs_pkg::Q_MAX_NEG);
				r   = sat ? W'(qrs_pkg::Q_MAX_NEG) : W'(-q);
			end else begin
				sat = (q > qrs_pkg::Q_MAX_POS);
				r   = sat ? W'(qrs_pkg::Q_MAX_POS) : W'(q);
			end
			if (qrs_pkg::mag_word(r) <= tol) begin
				r = '0;
			end
			finish_root = {sat, r};
		end
	endfunction

	assign adv      = !(out_valid_q && out_stall);
	assign in_stall = !adv;
	assign tol_w    = W'(tol_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= qrs_pkg::TOL_W'(1);
		end else if (cfg_wr_en) begin
			tol_q <= cfg_wr_data;
		end
	end

	// classification and discriminant
	always_comb begin
		ma = qrs_pkg::mag_word(a_s1);
		mb = qrs_pkg::mag_word(b_s1);
		mc = qrs_pkg::mag_word(c_s1);

		bb_x   = qrs_pkg::D_W'(bb_s2);
		ac4_x  = qrs_pkg::D_W'(ac_s2) << 2;
		d      = ac_neg_s2 ? (bb_x + ac4_x) : (bb_x - ac4_x);
		d_neg  = d[qrs_pkg::D_W-1];
		d_pos  = !d_neg && (d != '0);
		d_mag  = d_neg ? (-d) : d;
		tol_d  = qrs_pkg::D_W'(tol_q) << qrs_pkg::FRAC_BITS;
		d_near = (d_mag <= tol_d);

		ctx_nx.count    = qrs_pkg::CNT_NONE;
		ctx_nx.use1     = 1'b0;
		ctx_nx.use2     = 1'b0;
		ctx_nx.use_sqrt = 1'b0;
		ctx_nx.base     = -(qrs_pkg::NUM_W'(b_s2));
		ctx_nx.den      = (qrs_pkg::DEN_W+1)'(a_s2) <<< 1;
		if (na_s2) begin
			if (nb_s2) begin
				ctx_nx.count = nc_s2 ? qrs_pkg::CNT_INF : qrs_pkg::CNT_NONE;
				ctx_nx.den   = (qrs_pkg::DEN_W+1)'(1);
			end else begin
				ctx_nx.count = qrs_pkg::CNT_ONE;
				ctx_nx.use1  = 1'b1;
				ctx_nx.base  = -(qrs_pkg::NUM_W'(c_s2));
				ctx_nx.den   = (qrs_pkg::DEN_W+1)'(b_s2);
			end
		end else if (d_pos) begin
			ctx_nx.count    = qrs_pkg::CNT_TWO;
			ctx_nx.use1     = 1'b1;
			ctx_nx.use2     = 1'b1;
			ctx_nx.use_sqrt = 1'b1;
		end else if (d_near) begin
			ctx_nx.count = qrs_pkg::CNT_ONE;
			ctx_nx.use1  = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1      <= coef_a;
			b_s1      <= coef_b;
			c_s1      <= coef_c;
			a_s2      <= a_s1;
			b_s2      <= b_s1;
			c_s2      <= c_s1;
			bb_s2     <= mb * mb;
			ac_s2     <= ma * mc;
			na_s2     <= (ma <= tol_w);
			nb_s2     <= (mb <= tol_w);
			nc_s2     <= (mc <= tol_w);
			ac_neg_s2 <= a_s1[W-1] ^ c_s1[W-1];
			ctx_s3    <= ctx_nx;
			rad_s3    <= (!na_s2 && d_pos) ? d[qrs_pkg::RAD_W-1:0] : '0;
		end
	end

	// square root cells
	assign sq_rad[0]  = rad_s3;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;

	for (genvar k = 0; k < SQ; k++) begin : g_sq
		qrs_sqrt_cell u_cell (
			.clk      (clk),
			.en       (adv),
			.rad_in   (sq_rad[k]),
			.rem_in   (sq_rem[k]),
			.root_in  (sq_root[k]),
			.rad_out  (sq_rad[k+1]),
			.rem_out  (sq_rem[k+1]),
			.root_out (sq_root[k+1])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctxsq_q[0] <= ctx_s3;
			for (int k = 1; k < SQ; k++) begin
				ctxsq_q[k] <= ctxsq_q[k-1];
			end
		end
	end

	// numerators and denominator
	always_comb begin
		ctx_last = ctxsq_q[SQ-1];
		s_ext    = ctx_last.use_sqrt ? $signed(qrs_pkg::NUM_W'(sq_root[SQ])) : '0;
		n1       = ctx_last.base - s_ext;
		n2       = ctx_last.base + s_ext;
		n1_mag   = n1[qrs_pkg::NUM_W-1] ? qrs_pkg::NUM_W'(-n1) : qrs_pkg::NUM_W'(n1);
		n2_mag   = n2[qrs_pkg::NUM_W-1] ? qrs_pkg::NUM_W'(-n2) : qrs_pkg::NUM_W'(n2);
		den_s    = ctx_last.den;
		den_abs  = den_s[qrs_pkg::DEN_W] ? (-den_s) : den_s;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_n_q.count <= ctx_last.count;
			ctx_n_q.use1  <= ctx_last.use1;
			ctx_n_q.use2  <= ctx_last.use2;
			ctx_n_q.neg1  <= n1[qrs_pkg::NUM_W-1] ^ den_s[qrs_pkg::DEN_W];
			ctx_n_q.neg2  <= n2[qrs_pkg::NUM_W-1] ^ den_s[qrs_pkg::DEN_W];
			dvd1_n_q      <= {n1_mag, {qrs_pkg::FRAC_BITS{1'b0}}};
			dvd2_n_q      <= {n2_mag, {qrs_pkg::FRAC_BITS{1'b0}}};
			den_n_q       <= den_abs[qrs_pkg::DEN_W-1:0];
		end
	end

	// divider cells
	assign d1_den[0] = den_n_q;
	assign d2_den[0] = den_n_q;
	assign d1_dvd[0] = dvd1_n_q;
	assign d2_dvd[0] = dvd2_n_q;
	assign d1_rem[0] = '0;
	assign d2_rem[0] = '0;
	assign d1_quo[0] = '0;
	assign d2_quo[0] = '0;

	for (genvar k = 0; k < DV; k++) begin : g_dv
		qrs_div_cell u_low (
			.clk     (clk),
			.en      (adv),
			.den_in  (d1_den[k]),
			.dvd_in  (d1_dvd[k]),
			.rem_in  (d1_rem[k]),
			.quo_in  (d1_quo[k]),
			.den_out (d1_den[k+1]),
			.dvd_out (d1_dvd[k+1]),
			.rem_out (d1_rem[k+1]),
			.quo_out (d1_quo[k+1])
		);
		qrs_div_cell u_high (
			.clk     (clk),
			.en      (adv),
			.den_in  (d2_den[k]),
			.dvd_in  (d2_dvd[k]),
			.rem_in  (d2_rem[k]),
			.quo_in  (d2_quo[k]),
			.den_out (d2_den[k+1]),
			.dvd_out (d2_dvd[k+1]),
			.rem_out (d2_rem[k+1]),
			.quo_out (d2_quo[k+1])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctxdv_q[0] <= ctx_n_q;
			for (int k = 1; k < DV; k++) begin
				ctxdv_q[k] <= ctxdv_q[k-1];
			end
		end
	end

	// saturation, sign and zero forcing
	always_comb begin
		ctx_end = ctxdv_q[DV-1];
		fin1    = finish_root(d1_quo[DV], ctx_end.neg1, tol_w);
		fin2    = finish_root(d2_quo[DV], ctx_end.neg2, tol_w);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			root_low_q  <= ctx_end.use1 ? $signed(fin1[W-1:0]) : '0;
			root_high_q <= ctx_end.use2 ? $signed(fin2[W-1:0]) : '0;
			cnt_q       <= ctx_end.count;
			status_q    <= (ctx_end.use1 && fin1[W]) || (ctx_end.use2 && fin2[W]);
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_n_q       <= 1'b0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < SQ; k++) begin
				vsq_q[k] <= 1'b0;
			end
			for (int k = 0; k < DV; k++) begin
				vdv_q[k] <= 1'b0;
			end
		end else if (adv) begin
			v_s1     <= in_valid;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			vsq_q[0] <= v_s3;
			for (int k = 1; k < SQ; k++) begin
				vsq_q[k] <= vsq_q[k-1];
			end
			v_n_q    <= vsq_q[SQ-1];
			vdv_q[0] <= v_n_q;
			for (int k = 1; k < DV; k++) begin
				vdv_q[k] <= vdv_q[k-1];
			end
			out_valid_q <= vdv_q[DV-1];
		end
	end

	assign out_valid  = out_valid_q;
	assign root_low   = root_low_q;
	assign root_high  = root_high_q;
	assign root_count = cnt_q;
	assign status     = status_q;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result held");

	a_no_root_values: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (root_count == qrs_pkg::CNT_NONE || root_count == qrs_pkg::CNT_INF)
		|-> root_low == '0 && root_high == '0)
		else $error("roots nonzero with no finite root");

	a_high_only_two: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && root_count != qrs_pkg::CNT_TWO |-> root_high == '0)
		else $error("second root set without two roots");

	a_sat_extreme: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |->
		root_low == W'(qrs_pkg::Q_MAX_POS) || root_low == W'(qrs_pkg::Q_MAX_NEG) ||
		root_high == W'(qrs_pkg::Q_MAX_POS) || root_high == W'(qrs_pkg::Q_MAX_NEG))
		else $error("status set without a saturated root");

	a_status_needs_root: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> root_count == qrs_pkg::CNT_ONE || root_count == qrs_pkg::CNT_TWO)
		else $error("status set without a solved root");

endmodule

// ===== tb/quadratic_root_solver_checker.sv =====
// ----------------------------------------------------------------------------
// quadratic_root_solver_checker
// Watches both channels of the quadratic root solver, predicts each result from
// the accepted coefficients and the current tolerance, and compares in order.
// ----------------------------------------------------------------------------
module quadratic_root_solver_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [qrs_pkg::TOL_W-1:0]             cfg_wr_data,
	input  logic                                  in_valid,
	input  logic                                  in_stall,
	input  logic signed [qrs_pkg::WORD_BITS-1:0]  coef_a,
	input  logic signed [qrs_pkg::WORD_BITS-1:0]  coef_b,
	input  logic signed [qrs_pkg::WORD_BITS-1:0]  coef_c,
	input  logic                                  out_valid,
	input  logic                                  out_stall,
	input  logic signed [qrs_pkg::WORD_BITS-1:0]  root_low,
	input  logic signed [qrs_pkg::WORD_BITS-1:0]  root_high,
	input  logic [1:0]                            root_count,
	input  logic                                  status,
	output int                                    fail_count,
	output int                                    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [qrs_pkg::WORD_BITS-1:0] lo;
		logic signed [qrs_pkg::WORD_BITS-1:0] hi;
		qrs_pkg::count_t                      cnt;
		logic                                 sat;
	} roots_t;

	roots_t       roots_q[$];
	logic [15:0]  tol;

	function automatic logic is_small(input logic signed [127:0] v, input logic [15:0] t);
		logic signed [127:0] m;
		m = (v < 0) ? -v : v;
		return m <= t;
	endfunction

	// truncated num*2^F/den on magnitudes, saturated, then small values forced to zero
	function automatic logic signed [qrs_pkg::WORD_BITS-1:0] fixed_quotient(
		input logic signed [127:0] num, input logic signed [127:0] den,
		input logic [15:0] t, inout logic sat);
		logic          neg;
		logic [127:0]  q, mn, md;
		logic signed [127:0] r;
		neg = (num < 0) != (den < 0);
		mn = (num < 0) ? -num : num;
		md = (den < 0) ? -den : den;
		q = (mn << qrs_pkg::FRAC_BITS) / md;
		if (neg) begin
			if (q > (128'd1 << (qrs_pkg::WORD_BITS - 1))) begin
				sat = 1'b1;
				r = -(128'sd1 <<< (qrs_pkg::WORD_BITS - 1));
			end else
				r = -$signed(q);
		end else begin
			if (q > (128'd1 << (qrs_pkg::WORD_BITS - 1)) - 1) begin
				sat = 1'b1;
				r = (128'sd1 <<< (qrs_pkg::WORD_BITS - 1)) - 1;
			end else
				r = $signed(q);
		end
		if (is_small(r, t)) r = 0;
		return r[qrs_pkg::WORD_BITS-1:0];
	endfunction

	function automatic logic [127:0] int_sqrt(input logic [127:0] n);
		logic [127:0] res, b, t;
		res = 0;
		b = 128'd1 << 126;
		while (b != 0 && b > n) b = b >> 2;
		while (b != 0) begin
			t = res + b;
			if (n >= t) begin
				n = n - t;
				res = (res >> 1) + b;
			end else
				res = res >> 1;
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic roots_t predict(input logic signed [qrs_pkg::WORD_BITS-1:0] ca,
		input logic signed [qrs_pkg::WORD_BITS-1:0] cb,
		input logic signed [qrs_pkg::WORD_BITS-1:0] cc,
		input logic [15:0] t);
		roots_t              r;
		logic signed [127:0] a, b, c, d, s;
		logic                sat;
		a = ca; b = cb; c = cc;
		sat = 1'b0;
		r.lo = '0; r.hi = '0; r.cnt = qrs_pkg::CNT_NONE;
		if (is_small(a, t)) begin
			if (is_small(b, t))
				r.cnt = is_small(c, t) ? qrs_pkg::CNT_INF : qrs_pkg::CNT_NONE;
			else begin
				r.lo = fixed_quotient(-c, b, t, sat);
				r.cnt = qrs_pkg::CNT_ONE;
			end
		end else begin
			d = b * b - 4 * a * c;
			if (d > 0) begin
				s = $signed(int_sqrt(d));
				r.lo = fixed_quotient(-b - s, 2 * a, t, sat);
				r.hi = fixed_quotient(-b + s, 2 * a, t, sat);
				r.cnt = qrs_pkg::CNT_TWO;
			end else if (-d <= ($signed({112'd0, t}) <<< qrs_pkg::FRAC_BITS)) begin
				r.lo = fixed_quotient(-b, 2 * a, t, sat);
				r.cnt = qrs_pkg::CNT_ONE;
			end
		end
		r.sat = sat;
		return r;
	endfunction

	assign pending = roots_q.size();

	always_ff @(posedge clk or negedge arst_n) begin
		roots_t e;
		if (!arst_n) begin
			tol <= 16'd1;
			fail_count <= 0;
		end else begin
			if (cfg_wr_en) tol <= cfg_wr_data;
			if (in_valid && !in_stall) roots_q.push_back(predict(coef_a, coef_b, coef_c, tol));
			if (out_valid && !out_stall) begin
				if (roots_q.size() == 0) begin
					$error("result transfer with nothing expected");
					fail_count <= fail_count + 1;
				end else begin
					e = roots_q.pop_front();
					if (root_low !== e.lo || root_high !== e.hi || root_count !== e.cnt
						|| status !== e.sat) begin
						fail_count <= fail_count + 1;
						if (root_low !== e.lo)
							$error("root_low expected %0d actual %0d", e.lo, root_low);
						if (root_high !== e.hi)
							$error("root_high expected %0d actual %0d", e.hi, root_high);
						if (root_count !== e.cnt)
							$error("root_count expected %0d actual %0d", e.cnt, root_count);
						if (status !== e.sat)
							$error("status expected %0d actual %0d", e.sat, status);
					end
				end
			end
		end
	end
endmodule

// ===== tb/quadratic_root_solver_tb.sv =====
// ----------------------------------------------------------------------------
// quadratic_root_solver_tb
// Drives directed and random equations through the solver under several zero
// tolerances, with random idle bursts on both channels; the checker judges.
// ----------------------------------------------------------------------------
module quadratic_root_solver_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 89;

	logic                                 clk, arst_n;
	logic                                 cfg_wr_en;
	logic [qrs_pkg::TOL_W-1:0]            cfg_wr_data;
	logic                                 in_valid, in_stall, out_valid, out_stall;
	logic signed [qrs_pkg::WORD_BITS-1:0] coef_a, coef_b, coef_c, root_low, root_high;
	logic [1:0]                           root_count;
	logic                                 status;
	int                                   fail_count, pending;
	logic                                 calm;

	quadratic_root_solver uut (.*);
	quadratic_root_solver_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("quadratic_root_solver_tb: FAIL");
		$finish;
	end

	// receiver stall bursts
	initial begin
		int n;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 7);
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send(input logic signed [qrs_pkg::WORD_BITS-1:0] a,
		input logic signed [qrs_pkg::WORD_BITS-1:0] b,
		input logic signed [qrs_pkg::WORD_BITS-1:0] c);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		in_valid <= 1'b1;
		coef_a <= a; coef_b <= b; coef_c <= c;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
	endtask

	task automatic set_tol(input logic [qrs_pkg::TOL_W-1:0] v);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic signed [qrs_pkg::WORD_BITS-1:0] rnd_coef();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return $signed($urandom_range(0, 8)) - 4;
			2: return $signed($urandom_range(0, 2 ** 20)) - (2 ** 19);
			default: return $signed($urandom_range(0, 2 ** 24)) - (2 ** 23);
		endcase
	endfunction

	// random coefficients, or (x - p)(x - q) scaled by k so real roots dominate
	task automatic send_random();
		logic signed [63:0] p, q, k;
		case ($urandom_range(0, 3))
			0: send(rnd_coef(), rnd_coef(), rnd_coef());
			1: send($signed($urandom_range(0, 6)) - 3, rnd_coef(), rnd_coef());
			default: begin
				p = $signed($urandom_range(0, 200)) - 100;
				q = ($urandom_range(0, 1)) ? p : $signed($urandom_range(0, 200)) - 100;
				k = $signed($urandom_range(1, 64)) * (($urandom_range(0, 1)) ? 1 : -1);
				send(32'(k << 16), 32'(-k * (p + q) << 16), 32'(k * p * q << 16));
			end
		endcase
	endtask

	initial begin
		calm = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0; cfg_wr_data = '0;
		in_valid = 1'b0; coef_a = '0; coef_b = '0; coef_c = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send(32'sh0001_0000, 32'shFFFD_0000, 32'sh0002_0000);
		send(32'sh0001_0000, 32'sh0002_0000, 32'sh0001_0000);
		send(32'sh0001_0000, 32'sh0000_0000, 32'sh0001_0000);
		send(32'sh0000_0000, 32'sh0002_0000, 32'shFFFC_0000);
		send(32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000);
		send(32'sh0000_0001, 32'sh0000_0001, 32'sh0000_0005);
		send(32'sh0000_0000, 32'sh0000_0000, 32'sh0003_0000);
		send(32'sh0000_0002, 32'sh7FFF_FFFF, 32'sh8000_0000);
		send(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
		send(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		send(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		send(32'sh0000_0002, 32'sh0000_0000, 32'shFFFF_FFFF);
		send(32'sh0000_0000, 32'sh0000_0002, 32'sh7FFF_FFFF);
		send(32'sh0000_0000, 32'shFFFF_FFFE, 32'sh8000_0000);
		send(32'sh0000_0100, 32'sh0000_0000, 32'sh0000_0000);
		send(32'sh0001_0000, 32'sh0000_0000, 32'shFFFF_FFFF);
		send(32'shFFFF_0000, 32'sh0000_0000, 32'sh0004_0000);
		send(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555);
		send(32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA);

		// pause until everything is back
		drain();
		set_tol(16'd0);
		send(32'sh0000_0001, 32'sh0000_0000, 32'sh0000_0000);
		send(32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000);
		repeat (100) send_random();
		set_tol(16'hFFFF);
		repeat (100) send_random();
		set_tol(16'd300);
		repeat (100) send_random();
		set_tol(16'd1);
		repeat (80) send_random();
		calm = 1'b1;
		repeat (70) send_random();
		drain();
		if (fail_count == 0)
			$display("quadratic_root_solver_tb: PASS");
		else
			$display("quadratic_root_solver_tb: FAIL");
		$finish;
	end
endmodule
